// ===== rtl/core/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assertion macros used by the dnp_checker file
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clk_i edge, off while rst_ni is low
`define DNP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dnp check failed");

// a stalled transaction keeps valid high and its payload unchanged
`define DNP_ASSERT_HOLD(lbl, vld, rdy, dat) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (vld && !rdy) |=> (vld && $stable(dat))) \
    else $error("dnp stalled transaction changed");

`endif

// ===== rtl/core/dnp_pkg.sv =====
// ---------------------------------------------------------------------------
// dnp_pkg
// shared widths, character codes, status codes and structs of the decimal
// number parser
// ---------------------------------------------------------------------------
package dnp_pkg;

  // default accumulator width (magnitude bits plus one)
  localparam int unsigned ACC_BITS_DEF = 48;

  // field widths
  localparam int unsigned CH_W     = 8;
  localparam int unsigned MANT_W   = 48;
  localparam int unsigned FRAC_W   = 5;
  localparam int unsigned STATUS_W = 3;

  // character codes
  localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_W-1:0] CH_POINT = 8'h2E;
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;

  // largest fraction digit count
  localparam logic [FRAC_W-1:0] FRAC_MAX = 5'd31;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_BADCHAR  = 3'd2,
    ST_LEADPT   = 3'd3,
    ST_MULTIPT  = 3'd4,
    ST_TRAILPT  = 3'd5,
    ST_OVERFLOW = 3'd6
  } status_e;

  // one character transaction as held in the input register
  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            has_char;
    logic            last;
  } step_t;

  // one parse result
  typedef struct packed {
    logic signed [MANT_W-1:0] mantissa;
    logic [FRAC_W-1:0]        frac_digits;
    status_e                  status;
  } result_t;

endpackage

// ===== rtl/core/dnp_intf.sv =====
// ---------------------------------------------------------------------------
// dnp channel interfaces
// valid/ready channels for characters, results and the mode register
// ---------------------------------------------------------------------------

// character channel
interface dnp_in_if;
  logic                      valid;
  logic                      ready;
  logic [dnp_pkg::CH_W-1:0]  ch;
  logic                      has_char;
  logic                      last;

  modport source (output valid, output ch, output has_char, output last, input ready);
  modport sink   (input valid, input ch, input has_char, input last, output ready);
endinterface

// result channel
interface dnp_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dnp_pkg::MANT_W-1:0]  mantissa;
  logic [dnp_pkg::FRAC_W-1:0]         frac_digits;
  logic [dnp_pkg::STATUS_W-1:0]       status;

  modport source (output valid, output mantissa, output frac_digits, output status,
                  input ready);
  modport sink   (input valid, input mantissa, input frac_digits, input status,
                  output ready);
endinterface

// mode register write channel
interface dnp_cfg_if;
  logic valid;
  logic ready;
  logic real_mode;

  modport source (output valid, output real_mode, input ready);
  modport sink   (input valid, input real_mode, output ready);
endinterface

// ===== rtl/core/dnp_parse.sv =====
// ---------------------------------------------------------------------------
// dnp_parse
// parse state and the per-character step: sign, digits, point, errors,
// and the result formed on the last character
// ---------------------------------------------------------------------------
module dnp_parse #(
  parameter int unsigned ACC_BITS = dnp_pkg::ACC_BITS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_en_i,
  input  dnp_pkg::step_t   step_i,
  input  logic             real_mode_i,
  output dnp_pkg::result_t result_o
);
  import dnp_pkg::*;

  localparam int unsigned MAG_W  = ACC_BITS - 1;
  localparam int unsigned WIDE_W = ACC_BITS + 3;
  localparam int unsigned NEG_W  = (ACC_BITS > MANT_W) ? ACC_BITS : MANT_W;

  typedef enum logic [1:0] {
    PH_START,
    PH_SIGN,
    PH_BODY
  } phase_e;

  phase_e              phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [MAG_W-1:0]    acc_q, acc_d;
  logic                point_q, point_d;
  logic [FRAC_W-1:0]   frac_q, frac_d;
  status_e             err_q, err_d;

  logic                take;
  logic                is_digit;
  logic [3:0]          digit;
  logic [WIDE_W-1:0]   acc_x10;
  logic [WIDE_W-1:0]   limit;
  logic                mag_ovf;
  status_e             status;
  logic [NEG_W-1:0]    mag_ext;
  logic [NEG_W-1:0]    signed_val;

  // digit decode and acc*10+d against the magnitude limit
  assign take     = step_i.has_char && (err_q == ST_OK);
  assign is_digit = (step_i.ch >= CH_ZERO) && (step_i.ch <= CH_NINE);
  assign digit    = step_i.ch[3:0];
  assign acc_x10  = (WIDE_W'(acc_q) << 3) + (WIDE_W'(acc_q) << 1) + WIDE_W'(digit);
  assign limit    = {4'b0000, {MAG_W{1'b1}}};
  assign mag_ovf  = acc_x10 > limit;

  // next parse state for one character
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    point_d = point_q;
    frac_d  = frac_q;
    err_d   = err_q;
    if (take) begin
      if (step_i.ch == CH_MINUS && phase_q == PH_START) begin
        neg_d   = 1'b1;
        phase_d = PH_SIGN;
      end else if (step_i.ch == CH_POINT && real_mode_i) begin
        if (phase_q != PH_BODY) begin
          err_d = ST_LEADPT;
        end else if (point_q) begin
          err_d = ST_MULTIPT;
        end else begin
          point_d = 1'b1;
        end
      end else if (!is_digit) begin
        err_d = ST_BADCHAR;
      end else begin
        phase_d = PH_BODY;
        if (mag_ovf) begin
          err_d = ST_OVERFLOW;
        end else if (point_q && frac_q == FRAC_MAX) begin
          err_d = ST_OVERFLOW;
        end else begin
          if (point_q) begin
            frac_d = frac_q + FRAC_W'(1);
          end
          acc_d = acc_x10[MAG_W-1:0];
        end
      end
    end
  end

  // end-of-string status and signed mantissa
  always_comb begin
    status = err_d;
    if (err_d == ST_OK) begin
      if (phase_d != PH_BODY) begin
        status = ST_EMPTY;
      end else if (point_d && frac_d == '0) begin
        status = ST_TRAILPT;
      end
    end
    mag_ext    = NEG_W'(acc_d);
    signed_val = neg_d ? (NEG_W'(0) - mag_ext) : mag_ext;
    result_o.status = status;
    if (status == ST_OK) begin
      result_o.mantissa    = signed_val[MANT_W-1:0];
      result_o.frac_digits = frac_d;
    end else begin
      result_o.mantissa    = '0;
      result_o.frac_digits = '0;
    end
  end

  // parse state, back to start after the last character
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      acc_q   <= '0;
      point_q <= 1'b0;
      frac_q  <= '0;
      err_q   <= ST_OK;
    end else if (step_en_i) begin
      if (step_i.last) begin
        phase_q <= PH_START;
        neg_q   <= 1'b0;
        acc_q   <= '0;
        point_q <= 1'b0;
        frac_q  <= '0;
        err_q   <= ST_OK;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        point_q <= point_d;
        frac_q  <= frac_d;
        err_q   <= err_d;
      end
    end
  end

endmodule

// ===== rtl/core/decimal_number_parser_core.sv =====
// ---------------------------------------------------------------------------
// decimal_number_parser_core
// converts a decimal string, one character per transaction, into a signed
// mantissa, a fraction digit count and a status code
// ---------------------------------------------------------------------------
//  channel  | dir | payload                          | note
//  cfg_i    | in  | real_mode                        | always ready
//  in_i     | in  | ch, has_char, last               | one character
//  out_o    | out | mantissa, frac_digits, status    | one per last mark
//
// one character per cycle sustained unless a last character waits on a stalled result;
// a result reaches the output through the input register and then the result register
// each cycle does one acc*10+d add and limit compare plus the sign negate
// rst_ni clears the mode to integer parsing and the parse state to string start
// a stalled result holds the input register only when it carries a last mark
// ---------------------------------------------------------------------------
module decimal_number_parser_core #(
  parameter int unsigned ACC_BITS = dnp_pkg::ACC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  dnp_cfg_if.sink   cfg_i,
  dnp_in_if.sink    in_i,
  dnp_out_if.source out_o
);
  import dnp_pkg::*;

  logic    real_mode_q;
  logic    s1_valid_q;
  step_t   s1_q;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    out_free;
  logic    s1_go;
  logic    in_take;

  // handshake control
  assign out_free    = !out_valid_q || out_o.ready;
  assign s1_go       = s1_valid_q && (!s1_q.last || out_free);
  assign in_i.ready  = !s1_valid_q || s1_go;
  assign in_take     = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  // mode register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      real_mode_q <= 1'b0;
    end else if (cfg_i.valid) begin
      real_mode_q <= cfg_i.real_mode;
    end
  end

  // input register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_go) begin
      s1_valid_q <= 1'b0;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.ch       <= in_i.ch;
      s1_q.has_char <= in_i.has_char;
      s1_q.last     <= in_i.last;
    end
  end

  // parse step
  dnp_parse #(
    .ACC_BITS (ACC_BITS)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_en_i   (s1_go),
    .step_i      (s1_q),
    .real_mode_i (real_mode_q),
    .result_o    (res)
  );

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_q.last) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (s1_go && s1_q.last) begin
      out_q <= res;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.mantissa    = out_q.mantissa;
  assign out_o.frac_digits = out_q.frac_digits;
  assign out_o.status      = out_q.status;

endmodule

// ===== rtl/core/dnp_checker.sv =====
// ---------------------------------------------------------------------------
// dnp_checker
// port-level checks of the decimal number parser, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dnp_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_i,
  input logic                              cfg_real_mode_i,
  input logic                              out_valid_i,
  input logic                              out_ready_i,
  input logic signed [dnp_pkg::MANT_W-1:0] out_mantissa_i,
  input logic [dnp_pkg::FRAC_W-1:0]        out_frac_digits_i,
  input logic [dnp_pkg::STATUS_W-1:0]      out_status_i
);
  import dnp_pkg::*;

  logic                                mode_q;
  logic [MANT_W+FRAC_W+STATUS_W-1:0]   out_payload;
  logic                                out_err;
  logic                                out_no_value;

  // mode as seen on the register write channel
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_i) begin
      mode_q <= cfg_real_mode_i;
    end
  end

  assign out_payload  = {out_mantissa_i, out_frac_digits_i, out_status_i};

  // error result shown and an all-zero number
  assign out_err      = out_valid_i && (out_status_i != ST_OK);
  assign out_no_value = (out_mantissa_i == '0) && (out_frac_digits_i == '0);

  // a waiting result keeps its value
  `DNP_ASSERT_HOLD(a_out_hold, out_valid_i, out_ready_i, out_payload)

  // an error result carries no number
  `DNP_ASSERT(a_err_no_value, out_err |-> out_no_value)

  // integer mode never reports fraction digits
  `DNP_ASSERT(a_int_no_frac, (out_valid_i && !mode_q) |-> (out_frac_digits_i == '0))

endmodule

bind decimal_number_parser_core dnp_checker u_dnp_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .cfg_valid_i       (cfg_i.valid),
  .cfg_ready_i       (cfg_i.ready),
  .cfg_real_mode_i   (cfg_i.real_mode),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .out_mantissa_i    (out_o.mantissa),
  .out_frac_digits_i (out_o.frac_digits),
  .out_status_i      (out_o.status)
);

// ===== verif/dnp_parse_checker.sv =====
// ---------------------------------------------------------------------------
// dnp_parse_checker
// watches the mode, character and result channels of the decimal number
// parser, tracks the parse of each string and checks every result against
// the mantissa, fraction digit count and status worked out here
// ---------------------------------------------------------------------------
module dnp_parse_checker #(
  parameter int unsigned ACC_BITS = dnp_pkg::ACC_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dnp_cfg_if          cfg_i,
  dnp_in_if           in_i,
  dnp_out_if          res_i,
  output int unsigned pending_o,
  output int unsigned errors_o
);
  import dnp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // largest magnitude the accumulator may hold
  localparam logic [63:0] MAG_LIMIT = (64'd1 << (ACC_BITS - 1)) - 64'd1;
  localparam int unsigned PRINT_MAX = 50;

  typedef enum logic [1:0] {
    PH_START,
    PH_SIGN,
    PH_BODY
  } phase_e;

  // parse state of the string in progress
  logic        real_mode;
  phase_e      phase;
  logic        neg;
  logic [63:0] acc;
  logic        pt_seen;
  logic [4:0]  frac_cnt;
  status_e     first_err;

  result_t     pending_results[$];
  int unsigned mismatch_cnt;

  assign errors_o = mismatch_cnt;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    if (mismatch_cnt < PRINT_MAX) begin
      $display("%0t ns mismatch on %s: got %0d, want %0d", $time, what, got, want);
    end
    mismatch_cnt++;
  endtask

  task automatic clear_parse();
    phase     = PH_START;
    neg       = 1'b0;
    acc       = '0;
    pt_seen   = 1'b0;
    frac_cnt  = '0;
    first_err = ST_OK;
  endtask

  // one character of the string; nothing moves once an error is held
  task automatic parse_char(input logic [CH_W-1:0] c);
    logic [63:0] dig;
    if (first_err != ST_OK) return;
    if (c == CH_MINUS && phase == PH_START) begin
      neg   = 1'b1;
      phase = PH_SIGN;
      return;
    end
    if (c == CH_POINT && real_mode) begin
      if (phase != PH_BODY) first_err = ST_LEADPT;
      else if (pt_seen) first_err = ST_MULTIPT;
      else pt_seen = 1'b1;
      return;
    end
    if (c < CH_ZERO || c > CH_NINE) begin
      first_err = ST_BADCHAR;
      return;
    end
    phase = PH_BODY;
    dig   = {56'd0, c - CH_ZERO};
    // the digit must keep the magnitude within the limit
    if (acc > (MAG_LIMIT - dig) / 64'd10) begin
      first_err = ST_OVERFLOW;
      return;
    end
    if (pt_seen) begin
      if (frac_cnt >= FRAC_MAX) begin
        first_err = ST_OVERFLOW;
        return;
      end
      frac_cnt++;
    end
    acc = acc * 64'd10 + dig;
  endtask

  // end of string: build the result and start over
  task automatic close_string(output result_t r);
    logic [63:0] m;
    status_e     st;
    st = first_err;
    if (st == ST_OK) begin
      if (phase != PH_BODY) st = ST_EMPTY;
      else if (pt_seen && frac_cnt == 0) st = ST_TRAILPT;
    end
    r.status      = st;
    r.mantissa    = '0;
    r.frac_digits = '0;
    if (st == ST_OK) begin
      m             = neg ? (64'd0 - acc) : acc;
      r.mantissa    = m[MANT_W-1:0];
      r.frac_digits = frac_cnt;
    end
    clear_parse();
  endtask

  // results are checked before new strings are closed in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t made;
    if (!rst_ni) begin
      real_mode = 1'b0;
      clear_parse();
      pending_results.delete();
      mismatch_cnt = 0;
      pending_o <= 0;
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (pending_results.size() == 0) begin
          flag_mismatch("result with no string pending", res_i.mantissa, 0);
        end else begin
          want = pending_results.pop_front();
          if (res_i.mantissa !== want.mantissa)
            flag_mismatch("mantissa", res_i.mantissa, want.mantissa);
          if (res_i.frac_digits !== want.frac_digits)
            flag_mismatch("frac_digits", res_i.frac_digits, want.frac_digits);
          if (res_i.status !== want.status)
            flag_mismatch("status", res_i.status, want.status);
        end
      end
      if (in_i.valid && in_i.ready) begin
        if (in_i.has_char) parse_char(in_i.ch);
        if (in_i.last) begin
          close_string(made);
          pending_results.push_back(made);
        end
      end
      // a mode write applies from the next character on
      if (cfg_i.valid && cfg_i.ready) real_mode = cfg_i.real_mode;
      pending_o <= pending_results.size();
    end
  end

endmodule

// ===== verif/decimal_number_parser_core_tb.sv =====
// ---------------------------------------------------------------------------
// decimal_number_parser_core_tb
// drives number strings into the parser in integer and real mode, a short
// directed set first and then random well-formed, broken and noise strings,
// with random bursts on the character side and stalls on the result side;
// the checker beside the block compares every result
// ---------------------------------------------------------------------------
module decimal_number_parser_core_tb;
  import dnp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RST_CYCLES   = 11;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned SETTLE_WAIT  = 8;
  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned PHASE_CHARS  = 300;
  localparam logic [63:0] MAG_LIMIT    = (64'd1 << (ACC_BITS_DEF - 1)) - 64'd1;

  typedef logic [CH_W-1:0] char_t;

  logic        clk_i;
  logic        rst_ni;
  int unsigned pending;
  int unsigned errors;
  logic        hold_req;

  dnp_cfg_if cfg_if();
  dnp_in_if  chr_if();
  dnp_out_if res_if();

  decimal_number_parser_core u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (chr_if),
    .out_o  (res_if)
  );

  dnp_parse_checker u_checker (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_if),
    .in_i      (chr_if),
    .res_i     (res_if),
    .pending_o (pending),
    .errors_o  (errors)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // result side: changing stall patterns and one long hold-off
  initial begin : result_sink
    bit          hold_done;
    int unsigned pat_mode;
    int unsigned pat_left;
    int unsigned cyc;
    hold_done = 1'b0;
    pat_left  = 0;
    cyc       = 0;
    res_if.ready <= 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        if (pat_left == 0) begin
          pat_mode = $urandom_range(0, 3);
          pat_left = $urandom_range(16, 128);
        end
        pat_left--;
        case (pat_mode)
          0: res_if.ready <= 1'b1;
          1: res_if.ready <= 1'($urandom_range(0, 1));
          2: res_if.ready <= ($urandom_range(0, 3) == 0);
          default: res_if.ready <= (cyc % 3 != 0);
        endcase
      end
    end
  end

  // watchdog on cycles with no transaction on any channel
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((chr_if.valid && chr_if.ready) || (res_if.valid && res_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("status: fail");
    $finish;
  end

  // character side
  char_t       text[$];
  int unsigned burst_left;
  int unsigned chars_sent;
  bit          mode_now;

  // one transaction, after a random gap when the burst is used up
  task automatic put_item(input char_t c, input logic has, input logic lst);
    if (burst_left == 0) begin
      chr_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(1, 10);
    end
    chr_if.valid    <= 1'b1;
    chr_if.ch       <= c;
    chr_if.has_char <= has;
    chr_if.last     <= lst;
    @(posedge clk_i);
    while (!chr_if.ready) @(posedge clk_i);
    burst_left--;
    if (has || lst) chars_sent++;
  endtask

  // the text as one string, ended on its last character or by an end-only item
  task automatic send_text(input bit end_apart);
    bit apart;
    apart = end_apart || (text.size() == 0);
    for (int i = 0; i < text.size(); i++) begin
      if ($urandom_range(0, 15) == 0) put_item(char_t'($urandom_range(0, 255)), 1'b0, 1'b0);
      put_item(text[i], 1'b1, !apart && (i == text.size() - 1));
    end
    if (apart) put_item(char_t'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic send_literal(input string s);
    text.delete();
    for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
    send_text(1'b0);
  endtask

  // stop offering, wait for every result, then let the pipeline empty
  task automatic settle();
    chr_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_WAIT) @(posedge clk_i);
  endtask

  task automatic write_mode(input bit m);
    cfg_if.valid     <= 1'b1;
    cfg_if.real_mode <= m;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    mode_now = m;
  endtask

  task automatic add_digits(input int unsigned n);
    repeat (n) text.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
  endtask

  task automatic add_value(input logic [63:0] v);
    char_t digs[$];
    do begin
      digs.push_front(CH_ZERO + char_t'(v % 64'd10));
      v = v / 64'd10;
    end while (v != 0);
    foreach (digs[i]) text.push_back(digs[i]);
  endtask

  // random string: mostly numbers, some broken, some noise
  task automatic build_random_text();
    int unsigned pick;
    int unsigned pos;
    logic [63:0] mag;
    text.delete();
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      if ($urandom_range(0, 2) == 0) text.push_back(CH_MINUS);
      if (pick < 8) begin
        // magnitudes around the accumulator limit
        mag = $urandom_range(0, 1) ? MAG_LIMIT - 64'($urandom_range(0, 9))
                                   : MAG_LIMIT + 64'($urandom_range(1, 40));
        add_value(mag);
        if (mode_now && $urandom_range(0, 1))
          text.insert($urandom_range(text.size() - 14, text.size() - 1), CH_POINT);
      end else if (pick < 15) begin
        // long runs of zeros toward the fraction digit limit
        text.push_back(CH_ZERO);
        if (mode_now) text.push_back(CH_POINT);
        repeat ($urandom_range(28, 32)) text.push_back(CH_ZERO);
        add_digits(1);
      end else begin
        add_digits(($urandom_range(0, 7) == 0) ? $urandom_range(7, 17)
                                               : $urandom_range(1, 6));
        if (mode_now && $urandom_range(0, 2) != 0) begin
          text.push_back(CH_POINT);
          add_digits($urandom_range(1, 6));
        end
      end
      // broken forms of a number
      if (pick >= 70) begin
        case ($urandom_range(0, 4))
          0: text.insert($urandom_range(0, text.size()), char_t'($urandom_range(0, 255)));
          1: text.insert($urandom_range(1, text.size()), CH_MINUS);
          2: text.push_back(CH_POINT);
          3: begin
            pos = (text[0] == CH_MINUS) ? 1 : 0;
            text.insert(pos, CH_POINT);
          end
          default: text.insert($urandom_range(0, text.size()), CH_POINT);
        endcase
      end
    end else begin
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 5))
          0: text.push_back(CH_POINT);
          1: text.push_back(CH_MINUS);
          2: text.push_back(CH_ZERO + char_t'($urandom_range(0, 9)));
          default: text.push_back(char_t'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // stimulus and verdict
  initial begin : stimulus
    bit phase_modes[6];
    phase_modes = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b1};
    burst_left  = 0;
    chars_sent  = 0;
    mode_now    = 1'b0;
    rst_ni           <= 1'b0;
    hold_req         <= 1'b0;
    cfg_if.valid     <= 1'b0;
    cfg_if.real_mode <= 1'b0;
    chr_if.valid     <= 1'b0;
    chr_if.ch        <= '0;
    chr_if.has_char  <= 1'b0;
    chr_if.last      <= 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // integer mode: empty, sign only, bad characters, errors held
    write_mode(1'b0);
    send_literal("-");
    text.delete();
    send_text(1'b0);
    put_item(CH_NINE, 1'b0, 1'b0);
    send_literal("9");
    send_literal("-0");
    send_literal(".");
    send_literal("5-");
    text.delete();
    text.push_back(8'hFF);
    send_text(1'b0);
    text.delete();
    text.push_back(8'h00);
    text.push_back(CH_NINE);
    send_text(1'b0);
    settle();

    // real mode: point errors and a good fraction
    write_mode(1'b1);
    send_literal(".");
    send_literal("-.5");
    send_literal("1..");
    send_literal("1.");
    send_literal("-1.25");
    settle();

    // random phases; the third one holds the result side off for a while
    foreach (phase_modes[p]) begin
      write_mode(phase_modes[p]);
      if (p == 2) hold_req <= 1'b1;
      chars_sent = 0;
      while (chars_sent < PHASE_CHARS) begin
        build_random_text();
        send_text($urandom_range(0, 4) == 0);
      end
      settle();
    end

    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/dnp_pkg.sv
rtl/core/dnp_intf.sv
rtl/core/dnp_parse.sv
rtl/core/decimal_number_parser_core.sv
rtl/core/dnp_checker.sv
verif/dnp_parse_checker.sv
verif/decimal_number_parser_core_tb.sv
